// ===== rtl/kscs_pkg.sv =====
package kscs_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Scancode set 1 constants
    localparam logic [7:0] SC_LSHIFT = 8'h2A;
    localparam logic [7:0] SC_LCTRL  = 8'h1D;
    localparam logic [7:0] SC_LALT   = 8'h38;
    localparam logic [7:0] SC_PREFIX = 8'hE0;
    localparam logic [7:0] SC_ENTER  = 8'h1C;
    localparam logic [7:0] SC_TAB    = 8'h0F;

    localparam logic OP_CHAR    = 1'b0;
    localparam logic OP_SPECIAL = 1'b1;

    // Event steps, in emission order
    localparam int NUM_STEPS   = 6;
    localparam int STEP_MOD_DN = 0;
    localparam int STEP_PFX_DN = 1;
    localparam int STEP_KEY_DN = 2;
    localparam int STEP_KEY_UP = 3;
    localparam int STEP_PFX_UP = 4;
    localparam int STEP_MOD_UP = 5;

    typedef logic [NUM_STEPS-1:0] step_mask_t;

    typedef enum logic [1:0] {
        MOD_NONE  = 2'd0,
        MOD_SHIFT = 2'd1,
        MOD_CTRL  = 2'd2,
        MOD_ALT   = 2'd3
    } mod_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
        logic [4:0] special_key;
    } in_word_t;

    typedef struct packed {
        logic [7:0] scan_code;
        logic       key_down;
        logic       extended_flag;
        logic       last_event;
    } out_word_t;

    // Classified keystroke handed from front to back
    typedef struct packed {
        logic [7:0] code;
        mod_t       modifier;
        logic       ext;
    } desc_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    typedef struct packed {
        logic  hit;
        desc_t desc;
    } lookup_t;

    function automatic logic [7:0] alpha_code(input logic [4:0] idx);
        logic [7:0] r;
        unique case (idx)
            5'd0:  r = 8'h1E;  5'd1:  r = 8'h30;  5'd2:  r = 8'h2E;  5'd3:  r = 8'h20;
            5'd4:  r = 8'h12;  5'd5:  r = 8'h21;  5'd6:  r = 8'h22;  5'd7:  r = 8'h23;
            5'd8:  r = 8'h17;  5'd9:  r = 8'h24;  5'd10: r = 8'h25;  5'd11: r = 8'h26;
            5'd12: r = 8'h32;  5'd13: r = 8'h31;  5'd14: r = 8'h18;  5'd15: r = 8'h19;
            5'd16: r = 8'h10;  5'd17: r = 8'h13;  5'd18: r = 8'h1F;  5'd19: r = 8'h14;
            5'd20: r = 8'h16;  5'd21: r = 8'h2F;  5'd22: r = 8'h11;  5'd23: r = 8'h2D;
            5'd24: r = 8'h15;  5'd25: r = 8'h2C;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] numeral_code(input logic [3:0] idx);
        logic [7:0] r;
        unique case (idx)
            4'd0: r = 8'h0B;  4'd1: r = 8'h02;  4'd2: r = 8'h03;  4'd3: r = 8'h04;
            4'd4: r = 8'h05;  4'd5: r = 8'h06;  4'd6: r = 8'h07;  4'd7: r = 8'h08;
            4'd8: r = 8'h09;  4'd9: r = 8'h0A;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Punctuation: code and shift need; code zero means no key
    function automatic lookup_t punct_lookup(input logic [7:0] c);
        lookup_t    r;
        logic [7:0] code;
        logic       sh;
        sh = 1'b0;
        unique case (c)
            8'h20: code = 8'h39;              // space
            8'h2D: code = 8'h0C;              // -
            8'h3D: code = 8'h0D;              // =
            8'h5B: code = 8'h1A;              // [
            8'h5D: code = 8'h1B;              // ]
            8'h3B: code = 8'h27;              // ;
            8'h27: code = 8'h28;              // quote
            8'h60: code = 8'h29;              // backtick
            8'h5C: code = 8'h2B;              // backslash
            8'h2C: code = 8'h33;              // ,
            8'h2E: code = 8'h34;              // .
            8'h2F: code = 8'h35;              // /
            8'h21: begin code = 8'h02; sh = 1'b1; end  // !
            8'h40: begin code = 8'h03; sh = 1'b1; end  // @
            8'h23: begin code = 8'h04; sh = 1'b1; end  // #
            8'h24: begin code = 8'h05; sh = 1'b1; end  // $
            8'h25: begin code = 8'h06; sh = 1'b1; end  // %
            8'h5E: begin code = 8'h07; sh = 1'b1; end  // ^
            8'h26: begin code = 8'h08; sh = 1'b1; end  // &
            8'h2A: begin code = 8'h09; sh = 1'b1; end  // *
            8'h28: begin code = 8'h0A; sh = 1'b1; end  // (
            8'h29: begin code = 8'h0B; sh = 1'b1; end  // )
            8'h5F: begin code = 8'h0C; sh = 1'b1; end  // _
            8'h2B: begin code = 8'h0D; sh = 1'b1; end  // +
            8'h7B: begin code = 8'h1A; sh = 1'b1; end  // {
            8'h7D: begin code = 8'h1B; sh = 1'b1; end  // }
            8'h3A: begin code = 8'h27; sh = 1'b1; end  // :
            8'h22: begin code = 8'h28; sh = 1'b1; end  // double quote
            8'h7E: begin code = 8'h29; sh = 1'b1; end  // ~
            8'h7C: begin code = 8'h2B; sh = 1'b1; end  // |
            8'h3C: begin code = 8'h33; sh = 1'b1; end  // <
            8'h3E: begin code = 8'h34; sh = 1'b1; end  // >
            8'h3F: begin code = 8'h35; sh = 1'b1; end  // ?
            default: code = 8'h00;
        endcase
        r.hit           = (code != 8'h00);
        r.desc.code     = code;
        r.desc.modifier = sh ? MOD_SHIFT : MOD_NONE;
        r.desc.ext      = 1'b0;
        return r;
    endfunction

    function automatic lookup_t char_lookup(input logic [7:0] c);
        lookup_t    r;
        logic [7:0] off_lower;
        logic [7:0] off_upper;
        logic [7:0] off_digit;
        off_lower = c - 8'h61;
        off_upper = c - 8'h41;
        off_digit = c - 8'h30;
        r.hit           = 1'b1;
        r.desc.ext      = 1'b0;
        r.desc.modifier = MOD_NONE;
        r.desc.code     = 8'h00;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r.desc.code = alpha_code(off_lower[4:0]);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            r.desc.code     = alpha_code(off_upper[4:0]);
            r.desc.modifier = MOD_SHIFT;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.desc.code = numeral_code(off_digit[3:0]);
        end else if (c == 8'h0A || c == 8'h0D) begin
            r.desc.code = SC_ENTER;
        end else if (c == 8'h09) begin
            r.desc.code = SC_TAB;
        end else begin
            r = punct_lookup(c);
        end
        return r;
    endfunction

    function automatic lookup_t named_lookup(input logic [4:0] k);
        lookup_t r;
        r.hit           = 1'b1;
        r.desc.ext      = 1'b0;
        r.desc.modifier = MOD_NONE;
        unique case (k)
            5'd0:  r.desc.code = 8'h1C;
            5'd1:  r.desc.code = 8'h01;
            5'd2:  r.desc.code = 8'h0F;
            5'd3:  r.desc.code = 8'h0E;
            5'd4:  begin r.desc.code = 8'h48; r.desc.ext = 1'b1; end
            5'd5:  begin r.desc.code = 8'h50; r.desc.ext = 1'b1; end
            5'd6:  begin r.desc.code = 8'h4B; r.desc.ext = 1'b1; end
            5'd7:  begin r.desc.code = 8'h4D; r.desc.ext = 1'b1; end
            5'd8:  begin r.desc.code = 8'h47; r.desc.ext = 1'b1; end
            5'd9:  begin r.desc.code = 8'h4F; r.desc.ext = 1'b1; end
            5'd10: begin r.desc.code = 8'h49; r.desc.ext = 1'b1; end
            5'd11: begin r.desc.code = 8'h51; r.desc.ext = 1'b1; end
            5'd12: begin r.desc.code = 8'h52; r.desc.ext = 1'b1; end
            5'd13: begin r.desc.code = 8'h53; r.desc.ext = 1'b1; end
            5'd14: r.desc.code = 8'h3B;
            5'd15: r.desc.code = 8'h3C;
            5'd16: r.desc.code = 8'h3D;
            5'd17: r.desc.code = 8'h3E;
            5'd18: r.desc.code = 8'h3F;
            5'd19: r.desc.code = 8'h40;
            5'd20: r.desc.code = 8'h41;
            5'd21: r.desc.code = 8'h42;
            5'd22: r.desc.code = 8'h43;
            5'd23: r.desc.code = 8'h44;
            5'd24: r.desc.code = 8'h57;
            5'd25: r.desc.code = 8'h58;
            5'd26: begin r.desc.code = 8'h2E; r.desc.modifier = MOD_CTRL; end
            5'd27: begin r.desc.code = 8'h2C; r.desc.modifier = MOD_CTRL; end
            5'd28: begin r.desc.code = 8'h46; r.desc.modifier = MOD_CTRL; end
            5'd29: begin r.desc.code = 8'h3E; r.desc.modifier = MOD_ALT; end
            5'd30: begin r.desc.code = 8'h1C; r.desc.modifier = MOD_ALT; end
            default: begin r.desc.code = 8'h00; r.hit = 1'b0; end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] mod_scan(input mod_t m);
        logic [7:0] r;
        unique case (m)
            MOD_SHIFT: r = SC_LSHIFT;
            MOD_CTRL:  r = SC_LCTRL;
            MOD_ALT:   r = SC_LALT;
            default:   r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic step_mask_t step_mask(input desc_t d);
        step_mask_t m;
        m              = '0;
        m[STEP_MOD_DN] = (d.modifier != MOD_NONE);
        m[STEP_PFX_DN] = d.ext;
        m[STEP_KEY_DN] = 1'b1;
        m[STEP_KEY_UP] = 1'b1;
        m[STEP_PFX_UP] = d.ext;
        m[STEP_MOD_UP] = (d.modifier != MOD_NONE);
        return m;
    endfunction

endpackage

// ===== rtl/kscs_front.sv =====
module kscs_front
    import kscs_pkg::*;
(
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    input  q_status_t q_status,
    output logic      push,
    output desc_t     push_desc
);

    lookup_t lk;

    always_comb begin
        if (s_word.operation == OP_SPECIAL) begin
            lk = named_lookup(s_word.special_key);
        end else begin
            lk = char_lookup(s_word.char_code);
        end
    end

    // Take a word whenever the queue has room; drop keystrokes with no events
    assign s_ready   = !q_status.full;
    assign push      = s_valid && s_ready && lk.hit;
    assign push_desc = lk.desc;

endmodule

// ===== rtl/kscs_queue.sv =====
module kscs_queue
    import kscs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  desc_t     push_desc,
    input  logic      pop,
    output desc_t     head_desc,
    output q_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_status.full      = (count_reg == CNT_W'(DEPTH));
    assign q_status.not_empty = (count_reg != '0);
    assign head_desc          = slot_reg[rd_ptr_reg];

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && q_status.not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== rtl/kscs_back.sv =====
module kscs_back
    import kscs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  desc_t     head_desc,
    input  q_status_t q_status,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    desc_t      cur_reg, cur_next;
    step_mask_t rem_reg, rem_next;
    logic       m_valid_reg, m_valid_next;
    out_word_t  m_word_reg, m_word_next;

    desc_t      src_desc;
    step_mask_t src_mask;
    step_mask_t pick;
    logic       have_cur, out_free, emit;
    out_word_t  ev;

    assign have_cur = (rem_reg != '0);
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = out_free && (have_cur || q_status.not_empty);
    assign pop      = emit && !have_cur;

    assign src_desc = have_cur ? cur_reg : head_desc;
    assign src_mask = have_cur ? rem_reg : step_mask(head_desc);
    assign pick     = src_mask & (~src_mask + 1'b1);

    always_comb begin
        ev.last_event = ((src_mask & ~pick) == '0);
        priority if (pick[STEP_MOD_DN]) begin
            ev.scan_code = mod_scan(src_desc.modifier);
            ev.key_down = 1'b1;
            ev.extended_flag = 1'b0;
        end else if (pick[STEP_PFX_DN]) begin
            ev.scan_code = SC_PREFIX;
            ev.key_down = 1'b1;
            ev.extended_flag = 1'b1;
        end else if (pick[STEP_KEY_DN]) begin
            ev.scan_code = src_desc.code;
            ev.key_down = 1'b1;
            ev.extended_flag = src_desc.ext;
        end else if (pick[STEP_KEY_UP]) begin
            ev.scan_code = src_desc.code;
            ev.key_down = 1'b0;
            ev.extended_flag = src_desc.ext;
        end else if (pick[STEP_PFX_UP]) begin
            ev.scan_code = SC_PREFIX;
            ev.key_down = 1'b0;
            ev.extended_flag = 1'b1;
        end else begin
            ev.scan_code = mod_scan(src_desc.modifier);
            ev.key_down = 1'b0;
            ev.extended_flag = 1'b0;
        end
    end

    always_comb begin
        cur_next     = cur_reg;
        rem_next     = rem_reg;
        m_word_next  = m_word_reg;
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = emit;
        end
        if (emit) begin
            cur_next    = src_desc;
            rem_next    = src_mask & ~pick;
            m_word_next = ev;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// ===== rtl/keystroke_to_scancode_sequencer_top.sv =====
// Channel   Direction  Handshake           Word
// s_        in         s_valid / s_ready   in_word_t  (operation, char_code, special_key)
// m_        out        m_valid / m_ready   out_word_t (scan_code, key_down,
//                                                      extended_flag, last_event)
//
// Flow: the front takes one word per cycle while the queue has room; the event
//   sequencer in the back emits one event per cycle while m_ready allows, so a keystroke
//   costs two or four events there (plain key, or key wrapped in a modifier or an E0
//   prefix; no key carries both, so the six-step walk never runs full).
// Reset: aresetn, synchronous, clears queue pointers, sequencer progress and m_valid.
// Stalls: m_ready low holds the output register; the queue absorbs QUEUE_DEPTH
//   classified keystrokes before s_ready drops.
module keystroke_to_scancode_sequencer_top
    import kscs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    // Front to queue: classified keystroke, pushed only when it has events
    logic      push;
    desc_t     push_desc;

    // Queue to back: head entry and fill status
    desc_t     head_desc;
    q_status_t q_status;
    logic      pop;

    // Classify characters and named keys; drop unsupported ones here
    kscs_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .q_status  (q_status),
        .push      (push),
        .push_desc (push_desc)
    );

    // Decouple classification from event emission
    kscs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .q_status  (q_status)
    );

    // Walk modifier, prefix and key steps, one event per cycle while the output is free
    kscs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_desc (head_desc),
        .q_status  (q_status),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule

// ===== bench/keystroke_to_scancode_sequencer_top_test.sv =====
module keystroke_to_scancode_sequencer_top_test;
    import kscs_pkg::*;

    // Run shape
    localparam int RANDOM_KEYSTROKES = 105;  // random keystrokes that make events
    localparam int CHOKE_AT          = 40;   // hold the result side off at this point
    localparam int CHOKE_CYCLES      = 60;   // length of that hold-off
    localparam int CALM_FROM         = 85;   // from here on, no idling on either side
    localparam int DRAIN_CYCLES      = 40;   // queue of four plus up to four events per keystroke
    localparam int CYCLE_LIMIT       = 200000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_word;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_word;

    keystroke_to_scancode_sequencer_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    // Scan code tables, set 1
    logic [7:0] letter_scan [26] = '{
        8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17,
        8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13,
        8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C
    };

    logic [7:0] digit_scan [10] = '{
        8'h0B, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A
    };

    // {ascii, scan code, needs shift}
    logic [16:0] punct_scan [33] = '{
        {8'h20, 8'h39, 1'b0}, {8'h2D, 8'h0C, 1'b0}, {8'h3D, 8'h0D, 1'b0},
        {8'h5B, 8'h1A, 1'b0}, {8'h5D, 8'h1B, 1'b0}, {8'h3B, 8'h27, 1'b0},
        {8'h27, 8'h28, 1'b0}, {8'h60, 8'h29, 1'b0}, {8'h5C, 8'h2B, 1'b0},
        {8'h2C, 8'h33, 1'b0}, {8'h2E, 8'h34, 1'b0}, {8'h2F, 8'h35, 1'b0},
        {8'h21, 8'h02, 1'b1}, {8'h40, 8'h03, 1'b1}, {8'h23, 8'h04, 1'b1},
        {8'h24, 8'h05, 1'b1}, {8'h25, 8'h06, 1'b1}, {8'h5E, 8'h07, 1'b1},
        {8'h26, 8'h08, 1'b1}, {8'h2A, 8'h09, 1'b1}, {8'h28, 8'h0A, 1'b1},
        {8'h29, 8'h0B, 1'b1}, {8'h5F, 8'h0C, 1'b1}, {8'h2B, 8'h0D, 1'b1},
        {8'h7B, 8'h1A, 1'b1}, {8'h7D, 8'h1B, 1'b1}, {8'h3A, 8'h27, 1'b1},
        {8'h22, 8'h28, 1'b1}, {8'h7E, 8'h29, 1'b1}, {8'h7C, 8'h2B, 1'b1},
        {8'h3C, 8'h33, 1'b1}, {8'h3E, 8'h34, 1'b1}, {8'h3F, 8'h35, 1'b1}
    };

    // Named keys 0..30: {scan code, extended, modifier}
    logic [10:0] named_scan [31] = '{
        {8'h1C, 1'b0, MOD_NONE}, {8'h01, 1'b0, MOD_NONE},   // Enter, Escape
        {8'h0F, 1'b0, MOD_NONE}, {8'h0E, 1'b0, MOD_NONE},   // Tab, Backspace
        {8'h48, 1'b1, MOD_NONE}, {8'h50, 1'b1, MOD_NONE},   // Up, Down
        {8'h4B, 1'b1, MOD_NONE}, {8'h4D, 1'b1, MOD_NONE},   // Left, Right
        {8'h47, 1'b1, MOD_NONE}, {8'h4F, 1'b1, MOD_NONE},   // Home, End
        {8'h49, 1'b1, MOD_NONE}, {8'h51, 1'b1, MOD_NONE},   // PageUp, PageDown
        {8'h52, 1'b1, MOD_NONE}, {8'h53, 1'b1, MOD_NONE},   // Insert, Delete
        {8'h3B, 1'b0, MOD_NONE}, {8'h3C, 1'b0, MOD_NONE},   // F1..F12
        {8'h3D, 1'b0, MOD_NONE}, {8'h3E, 1'b0, MOD_NONE},
        {8'h3F, 1'b0, MOD_NONE}, {8'h40, 1'b0, MOD_NONE},
        {8'h41, 1'b0, MOD_NONE}, {8'h42, 1'b0, MOD_NONE},
        {8'h43, 1'b0, MOD_NONE}, {8'h44, 1'b0, MOD_NONE},
        {8'h57, 1'b0, MOD_NONE}, {8'h58, 1'b0, MOD_NONE},
        {8'h2E, 1'b0, MOD_CTRL}, {8'h2C, 1'b0, MOD_CTRL},   // CtrlC, CtrlZ
        {8'h46, 1'b0, MOD_CTRL},                            // CtrlBreak
        {8'h3E, 1'b0, MOD_ALT},  {8'h1C, 1'b0, MOD_ALT}     // AltF4, AltEnter
    };

    // Directed keystrokes. A row either spells out a plain two-event key by its
    // scan code, says the keystroke is silent, or leaves the events to the predictor.
    typedef struct packed {
        in_word_t   word;
        logic       spelled;   // events given in this row
        logic       silent;    // spelled row with no events at all
        logic [7:0] code;      // key pressed and released, no modifier, no prefix
    } probe_t;

    probe_t keystroke_probes [25] = '{
        // word: operation, char, key     spelled silent code
        {OP_CHAR,    8'h61, 5'h1F,        1'b1, 1'b0, 8'h1E},  // 'a', key field all ones
        {OP_CHAR,    8'h7A, 5'h00,        1'b0, 1'b0, 8'h00},  // 'z'
        {OP_CHAR,    8'h41, 5'h00,        1'b0, 1'b0, 8'h00},  // 'A' wrapped in shift
        {OP_CHAR,    8'h5A, 5'h15,        1'b0, 1'b0, 8'h00},  // 'Z'
        {OP_CHAR,    8'h30, 5'h0A,        1'b1, 1'b0, 8'h0B},  // '0'
        {OP_CHAR,    8'h39, 5'h00,        1'b1, 1'b0, 8'h0A},  // '9'
        {OP_CHAR,    8'h0A, 5'h00,        1'b1, 1'b0, 8'h1C},  // newline
        {OP_CHAR,    8'h0D, 5'h00,        1'b1, 1'b0, 8'h1C},  // carriage return acts as Enter
        {OP_CHAR,    8'h09, 5'h00,        1'b1, 1'b0, 8'h0F},  // tab
        {OP_CHAR,    8'h20, 5'h00,        1'b1, 1'b0, 8'h39},  // space
        {OP_CHAR,    8'h3F, 5'h00,        1'b0, 1'b0, 8'h00},  // '?' shifted punctuation
        {OP_CHAR,    8'h7E, 5'h00,        1'b0, 1'b0, 8'h00},  // '~'
        {OP_CHAR,    8'h00, 5'h00,        1'b1, 1'b1, 8'h00},  // control byte
        {OP_CHAR,    8'h7F, 5'h00,        1'b1, 1'b1, 8'h00},  // delete byte
        {OP_CHAR,    8'h80, 5'h00,        1'b1, 1'b1, 8'h00},  // high half
        {OP_CHAR,    8'hFF, 5'h1F,        1'b1, 1'b1, 8'h00},  // top byte
        {OP_SPECIAL, 8'hFF, 5'd0,         1'b1, 1'b0, 8'h1C},  // Enter, char field ignored
        {OP_SPECIAL, 8'h00, 5'd4,         1'b0, 1'b0, 8'h00},  // Up, extended
        {OP_SPECIAL, 8'h61, 5'd13,        1'b0, 1'b0, 8'h00},  // Delete, extended
        {OP_SPECIAL, 8'h00, 5'd25,        1'b1, 1'b0, 8'h58},  // F12
        {OP_SPECIAL, 8'h00, 5'd26,        1'b0, 1'b0, 8'h00},  // CtrlC
        {OP_SPECIAL, 8'h00, 5'd28,        1'b0, 1'b0, 8'h00},  // CtrlBreak
        {OP_SPECIAL, 8'h00, 5'd29,        1'b0, 1'b0, 8'h00},  // AltF4
        {OP_SPECIAL, 8'h00, 5'd30,        1'b0, 1'b0, 8'h00},  // AltEnter
        {OP_SPECIAL, 8'h61, 5'd31,        1'b1, 1'b1, 8'h00}   // key 31 means nothing
    };

    out_word_t awaited_events[$];   // events still owed by the block, oldest first
    int        keystrokes_sent;     // accepted keystrokes that owe at least one event
    int        mismatches = 0;
    int        cycle_count = 0;
    int        choke_requests;      // raised by the sender, served by the receiver
    int        choke_served = 0;
    int        choke_left;
    bit        calm;                // set for the last stretch: no idling anywhere

    // Clock and cycle count
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic out_word_t scan_event(input logic [7:0] code, input logic down,
                                             input logic ext);
        out_word_t e;
        e.scan_code     = code;
        e.key_down      = down;
        e.extended_flag = ext;
        e.last_event    = 1'b0;
        return e;
    endfunction

    // Append one event to the owed list.
    function automatic void owe_event(input out_word_t e);
        awaited_events.insert(awaited_events.size(), e);
    endfunction

    // Work out the events of one keystroke and queue them up.
    function automatic void scancodes_for(input in_word_t w);
        out_word_t   ev [6];
        int          n;
        logic [7:0]  c;
        logic [7:0]  code;
        logic [7:0]  mod_code;
        logic [10:0] entry;
        logic        ext;
        mod_t        modifier;
        n        = 0;
        c        = w.char_code;
        code     = 8'h00;
        ext      = 1'b0;
        modifier = MOD_NONE;
        if (w.operation == OP_CHAR) begin
            if (c >= 8'h61 && c <= 8'h7A) begin
                code = letter_scan[5'(c - 8'h61)];
            end else if (c >= 8'h41 && c <= 8'h5A) begin
                code     = letter_scan[5'(c - 8'h41)];
                modifier = MOD_SHIFT;
            end else if (c >= 8'h30 && c <= 8'h39) begin
                code = digit_scan[4'(c - 8'h30)];
            end else if (c == 8'h0A || c == 8'h0D) begin
                code = SC_ENTER;
            end else if (c == 8'h09) begin
                code = SC_TAB;
            end else begin
                for (int i = 0; i < 33; i++) begin
                    if (punct_scan[i][16:9] == c) begin
                        code     = punct_scan[i][8:1];
                        modifier = punct_scan[i][0] ? MOD_SHIFT : MOD_NONE;
                    end
                end
            end
        end else if (w.special_key != 5'd31) begin
            entry    = named_scan[w.special_key];
            code     = entry[10:3];
            ext      = entry[2];
            modifier = mod_t'(entry[1:0]);
        end
        // Unsupported bytes and key 31 owe nothing
        if (code == 8'h00) return;

        case (modifier)
            MOD_SHIFT: mod_code = SC_LSHIFT;
            MOD_CTRL:  mod_code = SC_LCTRL;
            MOD_ALT:   mod_code = SC_LALT;
            default:   mod_code = 8'h00;
        endcase

        // Modifier outermost, E0 prefix inside it, the key itself in the middle
        if (modifier != MOD_NONE) begin
            ev[n] = scan_event(mod_code, 1'b1, 1'b0);
            n = n + 1;
        end
        if (ext) begin
            ev[n] = scan_event(SC_PREFIX, 1'b1, 1'b1);
            n = n + 1;
        end
        ev[n] = scan_event(code, 1'b1, ext);
        n = n + 1;
        ev[n] = scan_event(code, 1'b0, ext);
        n = n + 1;
        if (ext) begin
            ev[n] = scan_event(SC_PREFIX, 1'b0, 1'b1);
            n = n + 1;
        end
        if (modifier != MOD_NONE) begin
            ev[n] = scan_event(mod_code, 1'b0, 1'b0);
            n = n + 1;
        end
        ev[n-1].last_event = 1'b1;
        for (int i = 0; i < n; i++) owe_event(ev[i]);
        keystrokes_sent++;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("cycle %0d: %s", cycle_count, what);
    endtask

    // Offer one keystroke word; enter and leave at a falling edge.
    task automatic type_keystroke(input in_word_t w, input logic spelled, input logic silent,
                                  input logic [7:0] code);
        int        gap;
        out_word_t release_ev;
        // Drop valid for a burst now and then, but never while the result side chokes:
        // the point there is to keep offering words until the block backs up
        if (!calm && choke_left == 0 && choke_requests == choke_served
                && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_word  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        // Word accepted at this edge: record what it owes
        if (!spelled) begin
            scancodes_for(w);
        end else if (!silent) begin
            owe_event(scan_event(code, 1'b1, 1'b0));
            release_ev            = scan_event(code, 1'b0, 1'b0);
            release_ev.last_event = 1'b1;
            owe_event(release_ev);
            keystrokes_sent++;
        end
        @(negedge aclk);
    endtask

    // Result side: random stall bursts, one long choke on request, none when calm.
    initial begin : receiver
        int idle_left;
        idle_left  = 0;
        choke_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (choke_served != choke_requests) begin
                choke_served = choke_requests;
                choke_left   = CHOKE_CYCLES;
            end
            if (choke_left > 0) begin
                choke_left--;
                m_ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                idle_left = $urandom_range(1, 9) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare every accepted event against the oldest one owed.
    always @(posedge aclk) begin : check_events
        out_word_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (awaited_events.size() == 0) begin
                report_mismatch($sformatf("event %h with none owed", m_word));
            end else begin
                want = awaited_events.pop_front();
                if (m_word.scan_code !== want.scan_code)
                    report_mismatch($sformatf("scan_code %h, want %h",
                                              m_word.scan_code, want.scan_code));
                if (m_word.key_down !== want.key_down)
                    report_mismatch($sformatf("key_down %b, want %b (code %h)",
                                              m_word.key_down, want.key_down, want.scan_code));
                if (m_word.extended_flag !== want.extended_flag)
                    report_mismatch($sformatf("extended_flag %b, want %b (code %h)",
                                              m_word.extended_flag, want.extended_flag,
                                              want.scan_code));
                if (m_word.last_event !== want.last_event)
                    report_mismatch($sformatf("last_event %b, want %b (code %h)",
                                              m_word.last_event, want.last_event,
                                              want.scan_code));
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("keystroke_to_scancode_sequencer_top_test: FAIL");
        $finish;
    end

    initial begin : stimulus
        int       base;
        int       pick;
        in_word_t w;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_word          = '0;
        keystrokes_sent = 0;
        choke_requests  = 0;
        calm            = 1'b0;

        // Hold reset, then release it at a falling edge
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed table
        for (int i = 0; i < 25; i++) begin
            type_keystroke(keystroke_probes[i].word, keystroke_probes[i].spelled,
                           keystroke_probes[i].silent, keystroke_probes[i].code);
        end

        // Random keystrokes: mostly printable characters and real named keys,
        // the rest raw bytes and the meaningless key number
        base = keystrokes_sent;
        while (keystrokes_sent - base < RANDOM_KEYSTROKES) begin
            if (keystrokes_sent - base >= CHOKE_AT && choke_requests == 0) choke_requests = 1;
            if (keystrokes_sent - base >= CALM_FROM) calm = 1'b1;
            w.char_code   = 8'($urandom_range(0, 255));
            w.special_key = 5'($urandom_range(0, 31));
            pick          = $urandom_range(0, 99);
            if (pick < 50) begin
                w.operation = OP_CHAR;
                w.char_code = 8'($urandom_range(8'h20, 8'h7E));
            end else if (pick < 60) begin
                w.operation = OP_CHAR;
            end else if (pick < 65) begin
                w.operation   = OP_SPECIAL;
                w.special_key = 5'd31;
            end else begin
                w.operation   = OP_SPECIAL;
                w.special_key = 5'($urandom_range(0, 30));
            end
            type_keystroke(w, 1'b0, 1'b0, 8'h00);
        end
        s_valid <= 1'b0;

        // Drain, then give stray events a chance to show up
        while (awaited_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("keystroke_to_scancode_sequencer_top_test: PASS");
        end else begin
            $display("keystroke_to_scancode_sequencer_top_test: FAIL");
        end
        $finish;
    end

endmodule
